@@ rtl/core/ifr_pkg.sv @@
// Shared types and codes for the image fragment reassembler.
// Holds the request and result item structs, request and status codes.
// No dependencies.
package ifr_pkg;

  // Request codes
  localparam logic [1:0] REQ_FRAG = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_NOP  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_ACCEPT   = 3'd1;
  localparam logic [2:0] ST_IGNORE   = 3'd2;
  localparam logic [2:0] ST_COMPLETE = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  // Fixed constants
  localparam logic [15:0] TIMEOUT_RESET  = 16'd20;
  localparam int          BYTES_PER_WORD = 4;
  localparam int          MAP_ROW_W      = 32;
  localparam int          MAP_SEL_W      = 5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] frag_id;
    logic [15:0] frag_total;
    logic [2:0]  word_index;
    logic [31:0] data_word;
    logic        last_beat;
    logic [11:0] read_address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [13:0] image_length_bytes;
    logic [31:0] read_data;
    logic [9:0]  packets_left;
  } rsp_t;

endpackage

@@ rtl/core/ifr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Read during write to the same address returns the old contents.
// No dependencies.
module ifr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/image_fragment_reassembler_core.sv @@
// Image fragment reassembler. Plain beats and reads sustain one item per cycle unless
// rsp_stall or a clearing pass holds them (store and bitmap reads issue at acceptance,
// forwarding covers the write of the item before); a held last beat or tick stalls intake.
// Completion or timeout runs a bitmap clearing pass over all MAP_DEPTH rows (16 at defaults).
// Synchronous reset runs the same clearing pass; no item is accepted until it ends.
module image_fragment_reassembler_core #(
  parameter int MAX_FRAGMENTS      = 512,
  parameter int WORDS_PER_FRAGMENT = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ifr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ifr_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);
  import ifr_pkg::*;

  localparam int STORE_DEPTH = MAX_FRAGMENTS * WORDS_PER_FRAGMENT;
  localparam int ST_AW       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_FRAGMENTS + 1);
  localparam int MAP_ROWS    = (MAX_FRAGMENTS + MAP_ROW_W - 1) / MAP_ROW_W;
  localparam int MAP_DEPTH   = (MAP_ROWS < 2) ? 2 : MAP_ROWS;
  localparam int MAP_AW      = $clog2(MAP_DEPTH);
  localparam int LEN_MUL     = WORDS_PER_FRAGMENT * BYTES_PER_WORD;

  // Control state
  logic [CNT_W-1:0]  expected_total;
  logic [CNT_W-1:0]  remaining_count;
  logic [15:0]       elapsed_ms;
  logic              beat_accepted;
  logic [15:0]       timeout_ms;
  logic              clear_busy;
  logic [MAP_AW-1:0] clear_row;
  logic              s1_valid;
  req_t              s1;

  // Handshake
  logic take;
  logic go;
  logic s1_may_clear;

  // Memory ports
  logic                 st_we;
  logic [ST_AW-1:0]     st_waddr;
  logic [ST_AW-1:0]     st_raddr;
  logic [31:0]          st_q;
  logic                 st_fwd;
  logic [31:0]          st_fwd_data;
  logic [31:0]          st_cur;
  logic                 map_we;
  logic [MAP_AW-1:0]    map_waddr;
  logic [MAP_ROW_W-1:0] map_wdata;
  logic [MAP_AW-1:0]    map_raddr;
  logic [MAP_ROW_W-1:0] map_q;
  logic                 map_fwd;
  logic [MAP_ROW_W-1:0] map_fwd_row;
  logic [MAP_ROW_W-1:0] map_cur;
  logic [MAP_ROW_W-1:0] map_mask;
  logic                 map_bit;

  // Execute results
  logic [CNT_W-1:0] exp_next;
  logic [CNT_W-1:0] rem_next;
  logic [15:0]      elapsed_next;
  logic [15:0]      elapsed_inc;
  logic             beat_next;
  logic             ok;
  logic             frag_store;
  logic             frag_mark;
  logic             start_clear;
  logic [2:0]       status_next;
  logic [13:0]      len_next;
  logic [31:0]      rdata_next;

  assign cfg_ready = 1'b1;

  // Item flow: one stage holding the item while its memory reads return
  assign go           = s1_valid && (!rsp_valid || !rsp_stall);
  assign s1_may_clear = ((s1.req_type == REQ_FRAG) && s1.last_beat) ||
                        (s1.req_type == REQ_TICK);
  assign req_stall    = clear_busy || (s1_valid && (!go || s1_may_clear));
  assign take         = req_valid && !req_stall;

  // Forward the last write where it hits the row or word just read
  assign st_cur   = st_fwd ? st_fwd_data : st_q;
  assign map_cur  = map_fwd ? map_fwd_row : map_q;
  assign map_bit  = map_cur[s1.frag_id[MAP_SEL_W-1:0]];
  assign map_mask = MAP_ROW_W'(1) << s1.frag_id[MAP_SEL_W-1:0];

  // Read addresses: new item on acceptance, else re-read for the held item
  assign st_raddr  = take ? ST_AW'(req.read_address) : ST_AW'(s1.read_address);
  assign map_raddr = take ? MAP_AW'(req.frag_id >> MAP_SEL_W)
                          : MAP_AW'(s1.frag_id >> MAP_SEL_W);

  // Write ports
  assign st_we     = go && frag_store;
  assign st_waddr  = ST_AW'(int'(s1.frag_id) * WORDS_PER_FRAGMENT + int'(s1.word_index));
  assign map_we    = clear_busy || (go && frag_mark);
  assign map_waddr = clear_busy ? clear_row : MAP_AW'(s1.frag_id >> MAP_SEL_W);
  assign map_wdata = clear_busy ? '0 : (map_cur | map_mask);

  assign elapsed_inc = (elapsed_ms != 16'hFFFF) ? elapsed_ms + 16'd1 : elapsed_ms;

  // Execute the held item against current state
  always_comb begin
    exp_next     = expected_total;
    rem_next     = remaining_count;
    elapsed_next = elapsed_ms;
    beat_next    = beat_accepted;
    ok           = 1'b0;
    frag_store   = 1'b0;
    frag_mark    = 1'b0;
    start_clear  = 1'b0;
    status_next  = ST_NONE;
    len_next     = '0;
    rdata_next   = '0;
    unique case (s1.req_type)
      REQ_FRAG: begin
        if (s1.word_index == '0) begin
          // Header beat: first header within size fixes the total
          if (s1.frag_total <= 16'(MAX_FRAGMENTS)) begin
            if (expected_total == '0) begin
              exp_next = CNT_W'(s1.frag_total);
              rem_next = CNT_W'(s1.frag_total);
            end
            ok = (s1.frag_total == 16'(exp_next)) &&
                 (s1.frag_id < 16'(exp_next)) && !map_bit;
            if (ok) begin
              elapsed_next = '0;
            end
          end
        end else begin
          ok = beat_accepted && (s1.frag_id < 16'(expected_total)) && !map_bit &&
               (int'(s1.word_index) < WORDS_PER_FRAGMENT);
        end
        beat_next = ok && !s1.last_beat;
        if (ok) begin
          frag_store  = 1'b1;
          status_next = ST_ACCEPT;
          if (s1.last_beat) begin
            if (rem_next != '0) begin
              rem_next = rem_next - CNT_W'(1);
            end
            if (rem_next == '0) begin
              // Image complete: report length, drop bookkeeping
              status_next = ST_COMPLETE;
              len_next    = 14'(int'(exp_next) * LEN_MUL);
              exp_next    = '0;
              rem_next    = '0;
              beat_next   = 1'b0;
              start_clear = 1'b1;
            end else begin
              frag_mark = 1'b1;
            end
          end
        end else begin
          status_next = ST_IGNORE;
        end
      end
      REQ_TICK: begin
        elapsed_next = elapsed_inc;
        if ((expected_total != '0) && (elapsed_inc > timeout_ms)) begin
          exp_next    = '0;
          rem_next    = '0;
          beat_next   = 1'b0;
          start_clear = 1'b1;
          status_next = ST_TIMEOUT;
        end
      end
      REQ_READ: begin
        if (int'(s1.read_address) < STORE_DEPTH) begin
          rdata_next = st_cur;
        end
      end
      default: begin
      end
    endcase
  end

  // Stage, state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      rsp_valid       <= 1'b0;
      expected_total  <= '0;
      remaining_count <= '0;
      elapsed_ms      <= '0;
      beat_accepted   <= 1'b0;
      timeout_ms      <= TIMEOUT_RESET;
      clear_busy      <= 1'b1;
      clear_row       <= '0;
      st_fwd          <= 1'b0;
      map_fwd         <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (go) begin
        s1_valid <= 1'b0;
      end

      if (go) begin
        rsp_valid       <= 1'b1;
        expected_total  <= exp_next;
        remaining_count <= rem_next;
        elapsed_ms      <= elapsed_next;
        beat_accepted   <= beat_next;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        timeout_ms <= cfg_data;
      end

      // Sweep the bitmap one row a cycle
      if (clear_busy) begin
        if (clear_row == MAP_AW'(MAP_DEPTH - 1)) begin
          clear_busy <= 1'b0;
        end
        clear_row <= clear_row + MAP_AW'(1);
      end else if (go && start_clear) begin
        clear_busy <= 1'b1;
        clear_row  <= '0;
      end

      st_fwd  <= st_we && (st_waddr == st_raddr);
      map_fwd <= map_we && (map_waddr == map_raddr);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= req;
    end
    if (go) begin
      rsp.status             <= status_next;
      rsp.image_length_bytes <= len_next;
      rsp.read_data          <= rdata_next;
      rsp.packets_left       <= 10'(rem_next);
    end
    st_fwd_data <= s1.data_word;
    map_fwd_row <= map_wdata;
  end

  ifr_ram #(
    .WIDTH(32),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (s1.data_word),
    .raddr (st_raddr),
    .rdata (st_q)
  );

  ifr_ram #(
    .WIDTH(MAP_ROW_W),
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_q)
  );

  // Checks
  a_left_bounded: assert property (@(posedge clk) disable iff (rst)
    remaining_count <= expected_total)
    else $error("remaining count exceeds expected total");

  a_complete_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == ST_COMPLETE)) |-> (rsp.packets_left == '0))
    else $error("completion reported with fragments left");

  a_clear_starts: assert property (@(posedge clk) disable iff (rst)
    (go && start_clear) |=> (clear_busy && (expected_total == '0)))
    else $error("bitmap clear not started after image end");

  a_no_take_over_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_may_clear) |-> !take)
    else $error("item taken while a clearing item is held");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for image_fragment_reassembler_core.
// Sends fragment beats, ticks and reads, predicts each result item and compares.
// Depends on ifr_pkg and the core RTL.
module tb_top;
  import ifr_pkg::*;

  localparam int FRAG_MAX    = 512;
  localparam int FRAG_WORDS  = 7;
  localparam int STORE_WORDS = FRAG_MAX * FRAG_WORDS;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // Predicted block state
  logic [31:0] store_words [STORE_WORDS];
  bit          store_filled [STORE_WORDS];
  int unsigned filled_addrs [$];
  bit          frag_done [FRAG_MAX];
  logic [9:0]  img_total = '0;
  logic [9:0]  frags_left = '0;
  logic [15:0] ms_elapsed = '0;
  logic        frag_open = 1'b0;
  logic [15:0] timeout_ms = TIMEOUT_RESET;

  rsp_t        awaited_rsps [$];
  int          error_count = 0;
  int          frag_beats = 0;
  bit          idling = 1'b1;
  int          stall_left = 0;

  always #1 clk = ~clk;

  image_fragment_reassembler_core #(
    .MAX_FRAGMENTS      (FRAG_MAX),
    .WORDS_PER_FRAGMENT (FRAG_WORDS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Drop the partial image and its bitmap
  function automatic void clear_image();
    frag_done  = '{default: 1'b0};
    img_total  = '0;
    frags_left = '0;
    frag_open  = 1'b0;
  endfunction

  function automatic bit frag_free(input logic [15:0] id);
    return (id < {6'd0, img_total}) && (id < FRAG_MAX) && !frag_done[id[8:0]];
  endfunction

  // Advance the predicted state by one accepted item and return its result
  function automatic rsp_t predict_rsp(input req_t r);
    rsp_t        o;
    logic        ok;
    int unsigned addr;
    int unsigned len;
    o = '0;
    case (r.req_type)
      REQ_FRAG: begin
        if (r.word_index == 3'd0) begin
          ok = 1'b0;
          if (r.frag_total <= FRAG_MAX) begin
            if (img_total == 0) begin
              img_total  = r.frag_total[9:0];
              frags_left = r.frag_total[9:0];
            end
            if (r.frag_total == {6'd0, img_total} && frag_free(r.frag_id)) begin
              ok = 1'b1;
              ms_elapsed = '0;
            end
          end
        end else begin
          ok = frag_open && frag_free(r.frag_id) && (r.word_index < FRAG_WORDS);
        end
        frag_open = ok;
        if (ok) begin
          addr = r.frag_id * FRAG_WORDS + r.word_index;
          store_words[addr[11:0]] = r.data_word;
          if (!store_filled[addr[11:0]]) filled_addrs.push_back(addr);
          store_filled[addr[11:0]] = 1'b1;
          o.status = ST_ACCEPT;
          if (r.last_beat) begin
            frag_done[r.frag_id[8:0]] = 1'b1;
            if (frags_left != 0) frags_left = frags_left - 1'b1;
            if (frags_left == 0) begin
              len = img_total * FRAG_WORDS * BYTES_PER_WORD;
              o.status = ST_COMPLETE;
              o.image_length_bytes = len[13:0];
              clear_image();
            end
          end
        end else begin
          o.status = ST_IGNORE;
        end
        if (r.last_beat) frag_open = 1'b0;
      end
      REQ_TICK: begin
        if (ms_elapsed != 16'hFFFF) ms_elapsed = ms_elapsed + 1'b1;
        if (img_total != 0 && ms_elapsed > timeout_ms) begin
          clear_image();
          o.status = ST_TIMEOUT;
        end
      end
      REQ_READ: begin
        if (r.read_address < STORE_WORDS) o.read_data = store_words[r.read_address];
      end
      default: ;
    endcase
    o.packets_left = frags_left;
    return o;
  endfunction

  // Compare each result item with the oldest prediction
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsps.size() == 0) begin
        report_mismatch("result with none awaited, status", rsp.status, ST_NONE);
      end else begin
        want = awaited_rsps.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", rsp.status, want.status);
        if (rsp.image_length_bytes !== want.image_length_bytes)
          report_mismatch("image_length_bytes", rsp.image_length_bytes,
                          want.image_length_bytes);
        if (rsp.read_data !== want.read_data)
          report_mismatch("read_data", rsp.read_data, want.read_data);
        if (rsp.packets_left !== want.packets_left)
          report_mismatch("packets_left", rsp.packets_left, want.packets_left);
      end
    end
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 9);
    end else begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end
  end

  // Send one item, hold it until accepted, then record its prediction
  task automatic send_req(input req_t r);
    if (idling && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (r.req_type == REQ_FRAG) frag_beats++;
    awaited_rsps.push_back(predict_rsp(r));
  endtask

  // Hold off the sender until every result item has arrived
  task automatic wait_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    timeout_ms = value;
  endtask

  function automatic req_t ctl_item(input logic [1:0] kind, input logic [11:0] addr);
    req_t r;
    r.req_type     = kind;
    r.frag_id      = 16'($urandom());
    r.frag_total   = 16'($urandom());
    r.word_index   = 3'($urandom());
    r.data_word    = $urandom();
    r.last_beat    = 1'($urandom());
    r.read_address = addr;
    return r;
  endfunction

  function automatic req_t frag_item(input int unsigned id, input int unsigned total,
                                     input int unsigned w, input bit last);
    req_t r;
    r = ctl_item(REQ_FRAG, 12'($urandom()));
    r.frag_id    = id[15:0];
    r.frag_total = total[15:0];
    r.word_index = w[2:0];
    r.last_beat  = last;
    return r;
  endfunction

  // Read only words already written, or addresses past the store
  function automatic logic [11:0] pick_read_addr();
    if (filled_addrs.size() != 0 && $urandom_range(0, 4) != 0)
      return 12'(filled_addrs[$urandom_range(0, filled_addrs.size() - 1)]);
    return 12'($urandom_range(STORE_WORDS, 4095));
  endfunction

  task automatic send_words(input int unsigned id, input int unsigned total,
                            input int first_w, input int last_w, input bit ends);
    for (int w = first_w; w <= last_w; w++)
      send_req(frag_item(id, total, w, ends && w == last_w));
  endtask

  task automatic send_fragment(input int unsigned id, input int unsigned total);
    send_words(id, total, 0, FRAG_WORDS - 1, 1'b1);
  endtask

  task automatic send_noise();
    req_t r;
    case ($urandom_range(0, 3))
      0: r = ctl_item(REQ_TICK, 12'($urandom()));
      1: r = ctl_item(REQ_READ, pick_read_addr());
      2: r = ctl_item(REQ_NOP, 12'($urandom()));
      default: begin
        r = ctl_item(REQ_FRAG, 12'($urandom()));
        if ($urandom_range(0, 1)) r.frag_id = 16'($urandom_range(0, 40));
        if ($urandom_range(0, 1)) r.frag_total = 16'($urandom_range(0, FRAG_MAX));
      end
    endcase
    send_req(r);
  endtask

  // Tick until any image in progress has been dropped
  task automatic flush_partial_image();
    while (img_total != 0) send_req(ctl_item(REQ_TICK, 12'($urandom())));
  endtask

  // One image in shuffled fragment order, with occasional faults
  task automatic send_image();
    int unsigned ids [$];
    int unsigned total;
    int unsigned id;
    int unsigned j;
    flush_partial_image();
    total = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
    for (int i = 0; i < total; i++) ids.push_back(i);
    for (int i = total - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      id = ids[i];
      ids[i] = ids[j];
      ids[j] = id;
    end
    foreach (ids[i]) begin
      id = ids[i];
      if ($urandom_range(0, 4) == 0) send_noise();
      case ($urandom_range(0, 19))
        // short fragment: its early last beat still marks it received
        0: send_words(id, total, 0, $urandom_range(0, FRAG_WORDS - 2), 1'b1);
        // id out of range first, then the real one
        1: begin
          send_fragment($urandom_range(total, 65535), total);
          send_fragment(id, total);
        end
        // duplicate fragment
        2: begin
          send_fragment(id, total);
          send_fragment(id, total);
        end
        // bad word index abandons the fragment, then resend
        3: begin
          send_words(id, total, 0, 2, 1'b0);
          send_req(frag_item(id, total, FRAG_WORDS, 1'b0));
          send_words(id, total, 3, FRAG_WORDS - 1, 1'b1);
          send_fragment(id, total);
        end
        // ticks in the middle of a fragment
        4: begin
          send_words(id, total, 0, 2, 1'b0);
          repeat ($urandom_range(1, 3)) send_req(ctl_item(REQ_TICK, 12'($urandom())));
          send_words(id, total, 3, FRAG_WORDS - 1, 1'b1);
        end
        // let the image time out
        5: begin
          repeat (timeout_ms + 1) send_req(ctl_item(REQ_TICK, 12'($urandom())));
          send_fragment(id, total);
        end
        default: send_fragment(id, total);
      endcase
    end
    flush_partial_image();
  endtask

  task automatic test_complete_image();
    send_fragment(1, 2);
    send_words(0, 2, 0, 0, 1'b1);
    send_req(ctl_item(REQ_READ, 12'd7));
    send_req(ctl_item(REQ_READ, 12'd13));
    send_req(ctl_item(REQ_READ, 12'hFFF));
    send_req(ctl_item(REQ_TICK, 12'd0));
    send_req(ctl_item(REQ_NOP, 12'd0));
  endtask

  task automatic test_header_checks();
    req_t r;
    // oversized images leave the state alone
    send_words(0, FRAG_MAX + 1, 0, 0, 1'b1);
    send_words(16'hFFFF, 16'hFFFF, 0, 0, 1'b1);
    // a zero total never accepts
    send_words(0, 0, 0, 0, 1'b1);
    // the first header fixes the total even though its id fails
    send_words(9, 4, 0, 0, 1'b0);
    send_req(ctl_item(REQ_TICK, 12'd0));
    send_req(ctl_item(REQ_TICK, 12'd0));
    // full size image, highest id as a single-beat fragment
    send_words(FRAG_MAX - 1, FRAG_MAX, 0, 0, 1'b1);
    send_words(FRAG_MAX - 1, FRAG_MAX, 0, 0, 1'b1);
    send_words(5, 3, 0, 0, 1'b1);
    send_words(FRAG_MAX, FRAG_MAX, 0, 0, 1'b1);
    // later beat with no accepted header
    send_words(3, FRAG_MAX, 3, 3, 1'b0);
    // word index out of range abandons the fragment
    send_words(300, FRAG_MAX, 0, 0, 1'b0);
    send_req(frag_item(300, FRAG_MAX, FRAG_WORDS, 1'b0));
    send_words(300, FRAG_MAX, 1, 1, 1'b1);
    r = ctl_item(REQ_READ, 12'((FRAG_MAX - 1) * FRAG_WORDS));
    send_req(r);
    send_req(ctl_item(REQ_TICK, 12'd0));
    send_req(ctl_item(REQ_TICK, 12'd0));
  endtask

  // Hold a partial image through a long timeout, then drop it once the limit is lowered
  task automatic test_long_timeout();
    flush_partial_image();
    wait_results();
    set_timeout(16'd40);
    idling = 1'b0;
    send_words(0, 2, 0, 0, 1'b1);
    repeat (40) send_req(ctl_item(REQ_TICK, 12'($urandom())));
    wait_results();
    set_timeout(16'd10);
    send_req(ctl_item(REQ_TICK, 12'($urandom())));
    wait_results();
    idling = 1'b1;
  endtask

  task automatic test_random_images(input int beats);
    int stop_at;
    stop_at = frag_beats + beats;
    while (frag_beats < stop_at) begin
      if ($urandom_range(0, 5) == 0) send_noise();
      else send_image();
    end
    wait_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_complete_image();
    wait_results();
    set_timeout(16'd1);
    test_header_checks();
    wait_results();

    set_timeout(16'd20);
    test_random_images(110);
    set_timeout(16'($urandom_range(2, 40)));
    test_random_images(90);
    set_timeout(16'd1);
    test_random_images(70);

    test_long_timeout();

    // last stretch without any idling
    idling = 1'b0;
    set_timeout(16'($urandom_range(3, 12)));
    test_random_images(30);

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[%0t] timed out with %0d results outstanding", $time, awaited_rsps.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
